// ===== hdl/raycast_wall_column_shader_defines.svh =====
`ifndef RAYCAST_WALL_COLUMN_SHADER_DEFINES_SVH
`define RAYCAST_WALL_COLUMN_SHADER_DEFINES_SVH

// same-cycle implication
`define RWCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define RWCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hdl/rwcs_pkg.sv =====
`timescale 1ns / 1ps
package rwcs_pkg;

	localparam int TEX_SIZE_DEF   = 64;
	localparam int FACE_COUNT_DEF = 4;
	localparam int MAX_ROWS_DEF   = 2048;

	localparam int COS_ENTRIES = 1025;
	localparam int DIV_N       = 32;
	localparam int DIV_D       = 25;

	typedef enum logic [1:0] {
		CMD_TEXEL = 2'd0,
		CMD_RAY   = 2'd1,
		CMD_SHADE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_CEIL  = 2'd0,
		KIND_WALL  = 2'd1,
		KIND_FLOOR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_CEIL   = 3'd0,
		REG_FLOOR  = 3'd1,
		REG_HEIGHT = 3'd2,
		REG_CENTER = 3'd3,
		REG_SCALE  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COS,
		ST_DIST,
		ST_DIVH,
		ST_WAITH,
		ST_DIVS,
		ST_WAITS,
		ST_EDGE,
		ST_SHMUL,
		ST_SHADDR,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [23:0]        ray_distance;
		logic signed [11:0] angle_offset;
		logic               is_vertical;
		logic [1:0]         face_lr;
		logic [1:0]         face_ud;
		logic [7:0]         wall_x_frac;
		logic [7:0]         wall_y_frac;
		logic [10:0]        row;
		logic [1:0]         tex_face;
		logic [11:0]        texel_index;
		logic [23:0]        texel_color;
	} req_t;

	typedef struct packed {
		logic [23:0] pixel_color;
		logic [1:0]  pixel_kind;
		logic [10:0] row_echo;
	} rsp_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [23:0] value;
	} cfg_t;

	typedef logic [14:0] cos_tab_t [0:COS_ENTRIES-1];

	function automatic logic [14:0] quarter_cos(input int unsigned i);
		logic [63:0] x, x2, term, r;
		longint      sum;
		x = (64'hC90FDAA2 * 64'(i)) >> 11;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = longint'(term);
		for (int k = 0; k < 12; k++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * k + 1) * (2 * k + 2));
			if ((k % 2) == 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			return 15'd0;
		end
		r = (64'(sum) + 64'd32768) >> 16;
		return (r > 64'd16384) ? 15'd16384 : r[14:0];
	endfunction

	function automatic cos_tab_t build_cos();
		cos_tab_t t;
		for (int i = 0; i < COS_ENTRIES; i++) begin
			t[i] = quarter_cos(i);
		end
		return t;
	endfunction

endpackage

// ===== hdl/rwcs_stream_if.sv =====
`timescale 1ns / 1ps
interface rwcs_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rwcs_ram.sv =====
`timescale 1ns / 1ps
module rwcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/rwcs_cos_rom.sv =====
`timescale 1ns / 1ps
module rwcs_cos_rom (
	input  logic        clk,
	input  logic [10:0] idx,
	output logic [14:0] cos_q
);
	import rwcs_pkg::*;

	localparam cos_tab_t COS_TAB = build_cos();

	always_ff @(posedge clk) begin
		cos_q <= COS_TAB[idx];
	end
endmodule

// ===== hdl/rwcs_div.sv =====
`timescale 1ns / 1ps
module rwcs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rwcs_pkg::DIV_N-1:0]    dividend,
	input  logic [rwcs_pkg::DIV_D-1:0]    divisor,
	output logic                          done,
	output logic [rwcs_pkg::DIV_N-1:0]    quotient
);
	import rwcs_pkg::*;

	logic [DIV_D-1:0]         dvs_q;
	logic [DIV_N-1:0]         dvd_q;
	logic [DIV_D-1:0]         rem_q;
	logic [$clog2(DIV_N)-1:0] cnt_q;
	logic                     busy_q;
	logic [DIV_D:0]           trial;
	logic                     fits;

	assign trial = {rem_q, dvd_q[DIV_N-1]};
	assign fits = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(DIV_N)'(DIV_N - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q    <= divisor;
			dvd_q    <= dividend;
			rem_q    <= '0;
			quotient <= '0;
		end else if (busy_q) begin
			rem_q    <= fits ? DIV_D'(trial - {1'b0, dvs_q}) : trial[DIV_D-1:0];
			dvd_q    <= {dvd_q[DIV_N-2:0], 1'b0};
			quotient <= {quotient[DIV_N-2:0], fits};
		end
	end
endmodule

// ===== hdl/raycast_wall_column_shader.sv =====
`timescale 1ns / 1ps
// Shades one screen column of a textured raycaster. cmd 0 writes a texel into the
// texture RAM. cmd 1 sets up a column: one cosine ROM read, one multiply, then two
// passes of a shared bit-serial divider for strip height and texture step (either
// pass is skipped when its result saturates). cmd 2 shades a row: ceiling and floor
// rows go straight to output, wall rows pass through multiply, texture RAM read and
// output, and every row waits at output while the sink holds the output register. One
// command is processed at a time; the output register holds a result while the next
// command is accepted. Configuration writes are taken every cycle.
module raycast_wall_column_shader #(
	parameter int TEX_SIZE   = rwcs_pkg::TEX_SIZE_DEF,
	parameter int FACE_COUNT = rwcs_pkg::FACE_COUNT_DEF,
	parameter int MAX_ROWS   = rwcs_pkg::MAX_ROWS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rwcs_stream_if.sink   req,
	rwcs_stream_if.source rsp,
	rwcs_stream_if.sink   cfg
);
	import rwcs_pkg::*;

	localparam int TW    = $clog2(TEX_SIZE);
	localparam int DEPTH = FACE_COUNT * TEX_SIZE * TEX_SIZE;
	localparam int AW    = $clog2(DEPTH);

	st_t state_q, state_d;

	logic [23:0] ceil_q, floor_q, scale_q;
	logic [11:0] height_q;
	logic [10:0] center_q;

	logic [23:0]   strip_height_q;
	logic [10:0]   strip_top_q;
	logic [11:0]   strip_bottom_q;
	logic [1:0]    column_face_q;
	logic [TW-1:0] texture_column_q;
	logic [15:0]   texture_step_q;

	logic [23:0] dist_q;
	logic        cos_pos_q;
	logic [24:0] pd_q;
	logic [10:0] row_q;
	kind_t       kind_q;
	logic [39:0] prod_s1;

	logic        take;
	req_t        rd;
	logic [11:0] ang;
	logic [10:0] cos_idx;
	logic        cos_pos;
	logic [14:0] cos_val;
	logic [38:0] pd_full;

	logic              div_start, div_done;
	logic [DIV_N-1:0]  div_dvd, div_q;
	logic [DIV_D-1:0]  div_dvs;

	logic [22:0] half;
	logic signed [25:0] off;
	logic [23:0] off_c;
	logic signed [24:0] top_fix;
	logic [23:0] bot_sum;
	logic [15:0] bot_raw;
	logic [12:0] limit;

	logic [48:0]   ty_full;
	logic [TW-1:0] ty;
	logic          tex_we, tex_re;
	logic [AW-1:0] tex_waddr, tex_raddr;
	logic [23:0]   tex_rdata;
	logic          face_ok;
	logic          rsp_free;
	logic          rsp_load;

	assign rd = req.data;
	assign take = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp_free = !rsp.valid || rsp.ready;
	assign half = strip_height_q[23:1];

	assign ang = rd.angle_offset;
	always_comb begin
		if (ang <= 12'd1024) begin
			cos_idx = ang[10:0];
			cos_pos = 1'b1;
		end else if (ang <= 12'd2048) begin
			cos_idx = 11'(13'd2048 - {1'b0, ang});
			cos_pos = 1'b0;
		end else if (ang <= 12'd3072) begin
			cos_idx = 11'(ang - 12'd2048);
			cos_pos = 1'b0;
		end else begin
			cos_idx = 11'(13'd4096 - {1'b0, ang});
			cos_pos = 1'b1;
		end
	end

	rwcs_cos_rom u_cos (
		.clk   (clk),
		.idx   (cos_idx),
		.cos_q (cos_val)
	);

	assign pd_full = 39'(dist_q) * 39'(cos_val) + 39'd8192;

	always_comb begin
		div_dvd = {8'd0, scale_q} << 8;
		div_dvs = pd_q;
		if (state_q == ST_DIVS) begin
			div_dvd = DIV_N'(32'd1 << 24);
			div_dvs = DIV_D'(strip_height_q);
		end
	end
	assign div_start = (state_q == ST_DIVH) || (state_q == ST_DIVS);

	rwcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	assign top_fix = $signed({6'd0, center_q, 8'd0}) - $signed({2'd0, half});
	assign bot_sum = {5'd0, center_q, 8'd0} + {1'b0, half};
	assign bot_raw = bot_sum[23:8];
	assign limit = (13'(height_q) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : 13'(height_q);

	assign off = $signed({7'd0, row_q, 8'd0}) + $signed({3'd0, half})
	           - $signed({7'd0, center_q, 8'd0});
	assign off_c = off[25] ? 24'd0 : off[23:0];

	assign ty_full = 49'(prod_s1) * 49'(TEX_SIZE);
	assign ty = (ty_full[48:24] > 25'(TEX_SIZE - 1)) ? TW'(TEX_SIZE - 1) : ty_full[24+TW-1:24];
	assign face_ok = 4'(column_face_q) < 4'(FACE_COUNT);
	assign tex_raddr = AW'(32'(column_face_q) * 32'(TEX_SIZE * TEX_SIZE)
	                 + 32'(texture_column_q) * 32'(TEX_SIZE) + 32'(ty));
	assign tex_re = (state_q == ST_SHADDR);

	assign tex_we = take && (rd.cmd == CMD_TEXEL) && (4'(rd.tex_face) < 4'(FACE_COUNT))
	              && (17'(rd.texel_index) < 17'(TEX_SIZE * TEX_SIZE));
	assign tex_waddr = AW'(32'(rd.tex_face) * 32'(TEX_SIZE * TEX_SIZE) + 32'(rd.texel_index));

	rwcs_ram #(
		.WIDTH (24),
		.DEPTH (DEPTH)
	) u_tex (
		.clk   (clk),
		.we    (tex_we),
		.waddr (tex_waddr),
		.wdata (rd.texel_color),
		.re    (tex_re),
		.raddr (tex_raddr),
		.rdata (tex_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rsp_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take && rd.cmd == CMD_RAY) begin
					state_d = ST_COS;
				end else if (take && rd.cmd == CMD_SHADE) begin
					if ({1'b0, rd.row} >= strip_bottom_q || rd.row < strip_top_q) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_SHMUL;
					end
				end
			end
			ST_COS:    state_d = ST_DIST;
			ST_DIST:   state_d = ST_DIVH;
			ST_DIVH:   state_d = (pd_q == '0) ? ST_DIVS : ST_WAITH;
			ST_WAITH:  if (div_done) state_d = ST_DIVS;
			ST_DIVS:   state_d = (strip_height_q < 24'd256) ? ST_EDGE : ST_WAITS;
			ST_WAITS:  if (div_done) state_d = ST_EDGE;
			ST_EDGE:   state_d = ST_IDLE;
			ST_SHMUL:  state_d = ST_SHADDR;
			ST_SHADDR: state_d = ST_OUT;
			ST_OUT: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceil_q           <= '0;
			floor_q          <= '0;
			height_q         <= 12'd480;
			center_q         <= 11'd240;
			scale_q          <= '0;
			strip_height_q   <= '0;
			strip_top_q      <= '0;
			strip_bottom_q   <= '0;
			column_face_q    <= '0;
			texture_column_q <= '0;
			texture_step_q   <= '0;
			rsp.valid        <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.index)
					REG_CEIL:   ceil_q   <= cfg.data.value;
					REG_FLOOR:  floor_q  <= cfg.data.value;
					REG_HEIGHT: height_q <= cfg.data.value[11:0];
					REG_CENTER: center_q <= cfg.data.value[10:0];
					REG_SCALE:  scale_q  <= cfg.data.value;
					default:    ;
				endcase
			end
			if (take && rd.cmd == CMD_RAY) begin
				column_face_q    <= rd.is_vertical ? rd.face_lr : rd.face_ud;
				texture_column_q <= TW'((16'(rd.is_vertical ? rd.wall_y_frac : rd.wall_x_frac)
				                    * 16'(TEX_SIZE)) >> 8);
			end
			if (state_q == ST_DIVH && pd_q == '0) begin
				strip_height_q <= 24'hFFFFFF;
			end
			if (state_q == ST_WAITH && div_done) begin
				strip_height_q <= (div_q > 32'hFFFFFF) ? 24'hFFFFFF : div_q[23:0];
			end
			if (state_q == ST_DIVS && strip_height_q < 24'd256) begin
				texture_step_q <= 16'hFFFF;
			end
			if (state_q == ST_WAITS && div_done) begin
				texture_step_q <= (div_q > 32'hFFFF) ? 16'hFFFF : div_q[15:0];
			end
			if (state_q == ST_EDGE) begin
				strip_top_q    <= (top_fix <= 0) ? 11'd0 : top_fix[18:8];
				strip_bottom_q <= (17'(bot_raw) > 17'(limit)) ? limit[11:0] : bot_raw[11:0];
			end
			if (rsp_load) begin
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dist_q    <= rd.ray_distance;
			cos_pos_q <= cos_pos;
			row_q     <= rd.row;
			if ({1'b0, rd.row} >= strip_bottom_q) begin
				kind_q <= KIND_FLOOR;
			end else if (rd.row < strip_top_q) begin
				kind_q <= KIND_CEIL;
			end else begin
				kind_q <= KIND_WALL;
			end
		end
		if (state_q == ST_COS) begin
			pd_q <= cos_pos_q ? pd_full[38:14] : '0;
		end
		if (state_q == ST_SHMUL) begin
			prod_s1 <= 40'(off_c) * 40'(texture_step_q);
		end
		if (rsp_load) begin
			rsp.data.pixel_kind <= kind_q;
			rsp.data.row_echo   <= row_q;
			case (kind_q)
				KIND_CEIL:  rsp.data.pixel_color <= ceil_q;
				KIND_FLOOR: rsp.data.pixel_color <= floor_q;
				default:    rsp.data.pixel_color <= face_ok ? tex_rdata : 24'd0;
			endcase
		end
	end
endmodule

// ===== hdl/rwcs_checker.sv =====
`timescale 1ns / 1ps
`include "raycast_wall_column_shader_defines.svh"
module rwcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_cmd,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_kind,
	input logic [10:0] rsp_row
);
	import rwcs_pkg::*;

	`RWCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_row) && $stable(rsp_kind), "stalled transaction changed")
	`RWCS_ASSERT_NOW(a_kind_code, rsp_valid, rsp_kind != 2'd3, "bad pixel kind")
	`RWCS_ASSERT_NEXT(a_ray_busy, req_valid && req_ready && req_cmd == CMD_RAY, !req_ready, "ray setup did not hold off input")
	`RWCS_ASSERT_NEXT(a_shade_busy, req_valid && req_ready && req_cmd == CMD_SHADE, !req_ready, "shade did not hold off input")
endmodule

bind raycast_wall_column_shader rwcs_checker u_rwcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_cmd   (req.data.cmd),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.data.pixel_kind),
	.rsp_row   (rsp.data.row_echo)
);
